// ----- sv/particle_pool_age_blend_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Particle pool assertion macros
// Assertion helpers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_POOL_AGE_BLEND_UNIT_DEFINES_SVH
`define PARTICLE_POOL_AGE_BLEND_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset
`define PPAB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("particle pool assertion failed");
// Check that a condition never holds outside reset
`define PPAB_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("particle pool forbidden condition");
`else
`define PPAB_ASSERT(lbl, clk, rst, prop)
`define PPAB_NEVER(lbl, clk, rst, expr)
`endif
`endif

// ----- sv/ppab_pkg.sv -----
// ----------------------------------------------------------------------------
// Particle pool package
// Types, codes and presets shared by the particle pool modules.
// ----------------------------------------------------------------------------
package ppab_pkg;

   localparam logic       CMD_SPAWN = 1'b0;
   localparam logic       CMD_TICK  = 1'b1;
   localparam logic       KIND_STAR  = 1'b0;
   localparam logic       KIND_SMOKE = 1'b1;
   localparam logic [1:0] STAT_SPAWN_OK  = 2'd0;
   localparam logic [1:0] STAT_POOL_FULL = 2'd1;
   localparam logic [1:0] STAT_REPORT    = 2'd2;
   localparam logic       CSR_STAR_LIFE  = 1'b0;
   localparam logic       CSR_SMOKE_LIFE = 1'b1;

   localparam logic [23:0] STAR_LIFE_RST  = 24'd61440;
   localparam logic [23:0] SMOKE_LIFE_RST = 24'd1024;

   localparam logic [15:0] STAR_SIZE_FROM  = 16'd2560;
   localparam logic [15:0] STAR_SIZE_TO    = 16'd15360;
   localparam logic [15:0] SMOKE_SIZE_FROM = 16'd3072;
   localparam logic [15:0] SMOKE_SIZE_TO   = 16'd7680;
   localparam logic [15:0] COLOR_FULL      = 16'd255;
   localparam logic [15:0] COLOR_NONE      = 16'd0;
   localparam logic [16:0] BLEND_ONE       = 17'd65536;
   localparam int          DIV_STEPS       = 16;

   typedef struct packed {
      logic               cmd;
      logic [31:0]        now;
      logic               kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [7:0]         blue_seed;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         slot;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [13:0]        size_now;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic [7:0]         alpha;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic               kind;
      logic [31:0]        stamp;
      logic [7:0]         blue_start;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPAWN,
      ST_SCAN,
      ST_CHECK,
      ST_DIV,
      ST_MIX,
      ST_FLUSH
   } ctl_state_type;

   typedef struct packed {
      logic capture;
      logic spawn;
      logic rd;
      logic clr_live;
      logic div_init;
      logic div_step;
      logic mix_load;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic live_hit;
      logic expired;
   } dp_status_type;

   // Rounded linear blend: (a*(1-w) + b*w + half) >> 16
   function automatic logic [15:0] mix(input logic [15:0] a, input logic [15:0] b,
                                       input logic [16:0] w);
      logic [33:0] v;
      v = 34'(a) * 34'(BLEND_ONE - w) + 34'(b) * 34'(w) + 34'd32768;
      return v[31:16];
   endfunction

endpackage

// ----- sv/particle_pool_age_blend_unit.sv -----
// ----------------------------------------------------------------------------
// Particle pool age blend unit
// Pool of particle slots with spawn and per-tick age blending.
// ----------------------------------------------------------------------------
// Usage: drive req_data and raise start while busy is low; the item is taken
// on that edge. A spawn (cmd 0) returns one result on rsp_data with
// rsp_valid high for one cycle: the chosen slot and start values, or pool
// full. A tick (cmd 1) walks every slot in order: a free slot is skipped, an
// expired one is read and freed, and a survivor is read, age-checked, divided
// over 16 divide steps and blended. Each survivor's report leaves when the
// next survivor is blended or at the end of the walk, the final one with last
// set. A tick with no survivors returns nothing. The lifetime divider is
// bit-serial. The receiver cannot stall: results are one-cycle strobes.
// Lifetimes are written on the csr_ channel, which is always ready; write
// them only while busy is low. Reset empties the pool and restores default
// lifetimes.
// ----------------------------------------------------------------------------
`include "particle_pool_age_blend_unit_defines.svh"

module particle_pool_age_blend_unit #(
   parameter int POOL_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ppab_pkg::req_type req_data,
   output logic              rsp_valid,
   output ppab_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [23:0]       csr_data
);
   import ppab_pkg::*;

   localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   ctl_cmd_type       cmd;
   dp_status_type     stat;
   logic [SLOT_W-1:0] idx;

   assign csr_ready = 1'b1;

   ppab_ctrl #(.POOL_SLOTS(POOL_SLOTS), .SLOT_W(SLOT_W)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .start_cmd (req_data.cmd),
      .busy      (busy),
      .cmd       (cmd),
      .idx       (idx),
      .stat      (stat)
   );

   ppab_datapath #(.POOL_SLOTS(POOL_SLOTS), .SLOT_W(SLOT_W)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .idx       (idx),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Results only follow a busy cycle
   `PPAB_ASSERT(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy))
   // Spawn outcomes are always the final result
   `PPAB_ASSERT(a_spawn_last, clock, reset, (rsp_valid && rsp_data.status != STAT_REPORT) |-> rsp_data.last)
   // An accepted item makes the unit busy
   `PPAB_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)
   // Never emit an undefined status code
   `PPAB_NEVER(a_status_code, clock, reset, rsp_valid && rsp_data.status > STAT_REPORT)

endmodule

// ----- sv/ppab_ctrl.sv -----
// ----------------------------------------------------------------------------
// Particle pool controller
// Sequences spawn and tick items over the slot walk and the divider.
// ----------------------------------------------------------------------------
module ppab_ctrl #(
   parameter int POOL_SLOTS = 64,
   parameter int SLOT_W     = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    start_cmd,
   output logic                    busy,
   output ppab_pkg::ctl_cmd_type   cmd,
   output logic [SLOT_W-1:0]       idx,
   input  ppab_pkg::dp_status_type stat
);
   import ppab_pkg::*;

   ctl_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic              idx_last;

   assign idx_last = (idx_ff == SLOT_W'(POOL_SLOTS - 1));
   assign idx      = idx_ff;
   assign busy     = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = (start_cmd == CMD_SPAWN) ? ST_SPAWN : ST_SCAN;
         end
         ST_SPAWN: state_in = ST_IDLE;
         ST_SCAN: begin
            if (stat.live_hit) state_in = ST_CHECK;
            else if (idx_last) state_in = ST_FLUSH;
         end
         ST_CHECK: begin
            if (!stat.expired) state_in = ST_DIV;
            else if (idx_last) state_in = ST_FLUSH;
            else state_in = ST_SCAN;
         end
         ST_DIV: begin
            if (cnt_ff == 4'(DIV_STEPS - 1)) state_in = ST_MIX;
         end
         ST_MIX:   state_in = idx_last ? ST_FLUSH : ST_SCAN;
         ST_FLUSH: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:  cmd.capture = start;
         ST_SPAWN: cmd.spawn = 1'b1;
         ST_SCAN:  cmd.rd = stat.live_hit;
         ST_CHECK: begin
            cmd.clr_live = stat.expired;
            cmd.div_init = !stat.expired;
         end
         ST_DIV:   cmd.div_step = 1'b1;
         ST_MIX:   cmd.mix_load = 1'b1;
         ST_FLUSH: cmd.flush = 1'b1;
         default:  cmd = '0;
      endcase
   end

   // Advance slot index and step count
   always_comb begin
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      if (state_ff == ST_IDLE) idx_in = '0;
      if ((state_ff == ST_SCAN && !stat.live_hit && !idx_last) ||
          (state_ff == ST_CHECK && stat.expired && !idx_last) ||
          (state_ff == ST_MIX && !idx_last)) begin
         idx_in = idx_ff + 1'b1;
      end
      if (state_ff == ST_CHECK) cnt_in = '0;
      else if (state_ff == ST_DIV) cnt_in = cnt_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- sv/ppab_datapath.sv -----
// ----------------------------------------------------------------------------
// Particle pool datapath
// Slot store, live bits, lifetimes, age divider, blend and result registers.
// ----------------------------------------------------------------------------
module ppab_datapath #(
   parameter int POOL_SLOTS = 64,
   parameter int SLOT_W     = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ppab_pkg::req_type       req_data,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [23:0]             csr_data,
   input  ppab_pkg::ctl_cmd_type   cmd,
   input  logic [SLOT_W-1:0]       idx,
   output ppab_pkg::dp_status_type stat,
   output logic                    rsp_valid,
   output ppab_pkg::rsp_type       rsp_data
);
   import ppab_pkg::*;

   slot_entry_type    mem [POOL_SLOTS];
   slot_entry_type    rd_ff;
   req_type           req_ff;
   logic [POOL_SLOTS-1:0] live_ff;
   logic [23:0]       star_life_ff, smoke_life_ff;
   logic [23:0]       rem_ff;
   logic [16:0]       quo_ff;
   rsp_type           pend_ff, rsp_ff;
   logic              pend_vld_ff, rsp_vld_ff;

   logic [SLOT_W-1:0] free_idx;
   logic              pool_full;
   logic [31:0]       age;
   logic [23:0]       life;
   logic              init_ge, step_ge;
   logic [24:0]       rem_sh;
   logic [16:0]       blend;
   logic [15:0]       blue_from;
   rsp_type           report, spawn_rsp, pend_out;
   slot_entry_type    new_entry;

   // Lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
         if (!live_ff[i]) free_idx = SLOT_W'(i);
      end
   end
   assign pool_full = &live_ff;

   // Age and expiry of the slot just read
   assign life    = (rd_ff.kind == KIND_SMOKE) ? smoke_life_ff : star_life_ff;
   assign age     = req_ff.now - rd_ff.stamp;
   assign stat.expired  = (age > {8'd0, life});
   assign stat.live_hit = live_ff[idx];

   // Restoring divide of age * 2^16 by lifetime, one bit a cycle
   assign init_ge = (age[23:0] >= life);
   assign rem_sh  = {rem_ff, 1'b0};
   assign step_ge = (rem_sh >= {1'b0, life});

   // Cap the blend at one: a set top bit means age equals life or life is zero
   assign blend = quo_ff[16] ? BLEND_ONE : quo_ff;

   // Compose a report from the blend
   assign blue_from = (rd_ff.kind == KIND_SMOKE) ? COLOR_FULL : {8'd0, rd_ff.blue_start};
   always_comb begin
      report          = '0;
      report.status   = STAT_REPORT;
      report.slot     = 6'(idx);
      report.out_x    = rd_ff.pos_x;
      report.out_y    = rd_ff.pos_y;
      report.out_z    = rd_ff.pos_z;
      report.size_now = 14'(mix((rd_ff.kind == KIND_SMOKE) ? SMOKE_SIZE_FROM : STAR_SIZE_FROM,
                                (rd_ff.kind == KIND_SMOKE) ? SMOKE_SIZE_TO : STAR_SIZE_TO,
                                blend));
      report.red      = 8'(COLOR_FULL);
      report.green    = 8'(COLOR_FULL);
      report.blue     = 8'(mix(blue_from, COLOR_FULL, blend));
      report.alpha    = 8'(mix(COLOR_FULL,
                               (rd_ff.kind == KIND_SMOKE) ? COLOR_NONE : COLOR_FULL,
                               blend));
      report.last     = 1'b0;
   end

   // Mark the held report as final on the flush
   always_comb begin
      pend_out      = pend_ff;
      pend_out.last = cmd.flush;
   end

   // New slot contents and the spawn response
   always_comb begin
      new_entry.kind       = req_ff.kind;
      new_entry.stamp      = req_ff.now;
      new_entry.blue_start = {1'b0, ((req_ff.blue_seed == 8'hFF) ? 7'd0 : req_ff.blue_seed[7:1])};
      new_entry.pos_x      = req_ff.pos_x;
      new_entry.pos_y      = req_ff.pos_y;
      new_entry.pos_z      = req_ff.pos_z;
      spawn_rsp            = '0;
      spawn_rsp.last       = 1'b1;
      if (pool_full) begin
         spawn_rsp.status = STAT_POOL_FULL;
      end else begin
         spawn_rsp.status   = STAT_SPAWN_OK;
         spawn_rsp.slot     = 6'(free_idx);
         spawn_rsp.out_x    = req_ff.pos_x;
         spawn_rsp.out_y    = req_ff.pos_y;
         spawn_rsp.out_z    = req_ff.pos_z;
         spawn_rsp.size_now = 14'((req_ff.kind == KIND_SMOKE) ? SMOKE_SIZE_FROM
                                                              : STAR_SIZE_FROM);
         spawn_rsp.red      = 8'(COLOR_FULL);
         spawn_rsp.green    = 8'(COLOR_FULL);
         spawn_rsp.blue     = (req_ff.kind == KIND_SMOKE) ? 8'(COLOR_FULL)
                                                          : new_entry.blue_start;
         spawn_rsp.alpha    = 8'(COLOR_FULL);
      end
   end

   // Slot store: write on spawn, registered read on walk
   always_ff @(posedge clock) begin
      if (cmd.spawn && !pool_full) mem[free_idx] <= new_entry;
      if (cmd.rd) rd_ff <= mem[idx];
   end

   // Hold item, divider state and pending report
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.div_init) begin
         quo_ff <= {16'd0, init_ge};
         rem_ff <= init_ge ? (age[23:0] - life) : age[23:0];
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[15:0], step_ge};
         rem_ff <= step_ge ? 24'(rem_sh - {1'b0, life}) : rem_sh[23:0];
      end
      if (cmd.mix_load) pend_ff <= report;
      if (cmd.spawn) rsp_ff <= spawn_rsp;
      else if ((cmd.mix_load || cmd.flush) && pend_vld_ff) rsp_ff <= pend_out;
   end

   // Control state: live bits, lifetimes, valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff       <= '0;
         star_life_ff  <= STAR_LIFE_RST;
         smoke_life_ff <= SMOKE_LIFE_RST;
         pend_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         if (cmd.spawn && !pool_full) live_ff[free_idx] <= 1'b1;
         if (cmd.clr_live) live_ff[idx] <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_STAR_LIFE:  star_life_ff  <= csr_data;
               CSR_SMOKE_LIFE: smoke_life_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.mix_load) pend_vld_ff <= 1'b1;
         else if (cmd.flush) pend_vld_ff <= 1'b0;
         rsp_vld_ff <= cmd.spawn || ((cmd.mix_load || cmd.flush) && pend_vld_ff);
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
